// ===== src/lhs_pkg.sv =====
// ----------------------------------------------------------------------------
// lhs_pkg
// Shared widths, types and state encoding of the label histogram similarity
// block.
// ----------------------------------------------------------------------------
package lhs_pkg;

  localparam int COUNT_BITS     = 16;
  localparam int ACC_BITS       = 24;
  localparam int FRACTION_BITS  = 16;
  localparam int SIM_BITS       = FRACTION_BITS + 1;
  // an excess at or above 2**EXC_BITS gives a zero quotient
  localparam int EXC_BITS       = 21;
  localparam int SQ_BITS        = 2 * EXC_BITS;
  localparam int CUBE_BITS      = 3 * EXC_BITS;
  localparam int DEN_BITS       = CUBE_BITS + 1;
  localparam int DIV_CNT_BITS   = $clog2(FRACTION_BITS + 1);

  localparam int QUEUE_DEPTH    = 2;
  localparam int QPTR_BITS      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_BITS      = $clog2(QUEUE_DEPTH + 1);

  localparam int IN_TDATA_BITS  = ((2 * COUNT_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_BITS = ((2 * SIM_BITS + 7) / 8) * 8;

  localparam int APB_ADDR_BITS  = 3;
  localparam int APB_DATA_BITS  = 32;
  // register index as seen on paddr[2]
  localparam logic REG_MEASURE_MODE = 1'b0;

  localparam logic MODE_OVERLAP = 1'b0;
  localparam logic MODE_CUBIC   = 1'b1;

  localparam logic [SIM_BITS-1:0] ONE_Q = SIM_BITS'(1) << FRACTION_BITS;

  typedef struct packed {
    logic                mode;
    logic [ACC_BITS-1:0] min_sum;
    logic [ACC_BITS-1:0] source_total;
    logic [ACC_BITS-1:0] query_total;
    logic [ACC_BITS-1:0] source_excess;
    logic [ACC_BITS-1:0] query_excess;
  } lhs_snap_t;

  typedef struct packed {
    logic                start;
    logic [ACC_BITS-1:0] num;
    logic [DEN_BITS-1:0] den;
  } lhs_div_req_t;

  typedef struct packed {
    logic                done;
    logic [SIM_BITS-1:0] quo;
  } lhs_div_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_SQUARE,
    ST_CUBE_LO,
    ST_CUBE_HI,
    ST_DEN,
    ST_DIVIDE,
    ST_OUTPUT
  } lhs_state_e;

endpackage

// ===== src/lhs_front.sv =====
// ----------------------------------------------------------------------------
// lhs_front
// Accepts count pairs, updates the five saturating accumulators and pushes a
// snapshot of them to the queue on the last element of a vector.
// ----------------------------------------------------------------------------
module lhs_front (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 mode_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [lhs_pkg::COUNT_BITS-1:0]       source_count_i,
  input  logic [lhs_pkg::COUNT_BITS-1:0]       query_count_i,
  input  logic                                 last_element_i,
  input  logic                                 queue_full_i,
  output logic                                 push_o,
  output lhs_pkg::lhs_snap_t                   snap_o
);

  localparam int AB = lhs_pkg::ACC_BITS;
  localparam int CB = lhs_pkg::COUNT_BITS;

  logic [AB-1:0] min_sum_q, source_total_q, query_total_q;
  logic [AB-1:0] source_excess_q, query_excess_q;
  logic [AB-1:0] min_sum_d, source_total_d, query_total_d;
  logic [AB-1:0] source_excess_d, query_excess_d;
  logic [CB-1:0] small_cnt;
  logic          accept;

  function automatic logic [AB-1:0] sat_add(input logic [AB-1:0] acc,
                                            input logic [CB-1:0] val);
    logic [AB:0] sum;
    sum = {1'b0, acc} + (AB + 1)'(val);
    return sum[AB] ? {AB{1'b1}} : sum[AB-1:0];
  endfunction

  assign in_ready_o = !queue_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = accept && last_element_i;

  always_comb begin
    small_cnt       = (source_count_i < query_count_i) ? source_count_i : query_count_i;
    min_sum_d       = sat_add(min_sum_q, small_cnt);
    source_total_d  = sat_add(source_total_q, source_count_i);
    query_total_d   = sat_add(query_total_q, query_count_i);
    source_excess_d = source_excess_q;
    query_excess_d  = query_excess_q;
    if (source_count_i > query_count_i) begin
      source_excess_d = sat_add(source_excess_q, source_count_i - query_count_i);
    end else if (query_count_i > source_count_i) begin
      query_excess_d = sat_add(query_excess_q, query_count_i - source_count_i);
    end
  end

  always_comb begin
    snap_o.mode          = mode_i;
    snap_o.min_sum       = min_sum_d;
    snap_o.source_total  = source_total_d;
    snap_o.query_total   = query_total_d;
    snap_o.source_excess = source_excess_d;
    snap_o.query_excess  = query_excess_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_sum_q       <= '0;
      source_total_q  <= '0;
      query_total_q   <= '0;
      source_excess_q <= '0;
      query_excess_q  <= '0;
    end else if (accept) begin
      if (last_element_i) begin
        // vector done: snapshot goes to the queue, start over
        min_sum_q       <= '0;
        source_total_q  <= '0;
        query_total_q   <= '0;
        source_excess_q <= '0;
        query_excess_q  <= '0;
      end else begin
        min_sum_q       <= min_sum_d;
        source_total_q  <= source_total_d;
        query_total_q   <= query_total_d;
        source_excess_q <= source_excess_d;
        query_excess_q  <= query_excess_d;
      end
    end
  end

endmodule

// ===== src/lhs_queue.sv =====
// ----------------------------------------------------------------------------
// lhs_queue
// Short FIFO of accumulator snapshots between the front and back ends.
// ----------------------------------------------------------------------------
module lhs_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  lhs_pkg::lhs_snap_t push_data_i,
  input  logic               pop_i,
  output lhs_pkg::lhs_snap_t pop_data_o,
  output logic               full_o,
  output logic               empty_o
);

  localparam int PB = lhs_pkg::QPTR_BITS;
  localparam int NB = lhs_pkg::QCNT_BITS;
  localparam int D  = lhs_pkg::QUEUE_DEPTH;

  lhs_pkg::lhs_snap_t entry_q [D];
  logic [PB-1:0] wr_ptr_q, rd_ptr_q;
  logic [NB-1:0] count_q;
  logic          do_push, do_pop;

  function automatic logic [PB-1:0] ptr_inc(input logic [PB-1:0] ptr);
    return (ptr == PB'(D - 1)) ? '0 : ptr + PB'(1);
  endfunction

  assign full_o     = (count_q == NB'(D));
  assign empty_o    = (count_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + NB'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - NB'(1);
      end
    end
  end

endmodule

// ===== src/lhs_div.sv =====
// ----------------------------------------------------------------------------
// lhs_div
// Radix-2 restoring divider for (num << FRACTION_BITS) / den with num <= den;
// one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lhs_div (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  lhs_pkg::lhs_div_req_t req_i,
  output lhs_pkg::lhs_div_rsp_t rsp_o
);

  localparam int DB = lhs_pkg::DEN_BITS;
  localparam int SB = lhs_pkg::SIM_BITS;
  localparam int KB = lhs_pkg::DIV_CNT_BITS;

  logic          busy_q, done_q;
  logic [KB-1:0] cnt_q;
  logic [DB-1:0] rem_q, den_q, num_ext, rem_nx;
  logic [SB-1:0] quo_q;
  logic [DB:0]   rem_sh;
  logic          ge, ge0;

  always_comb begin
    num_ext = DB'(req_i.num);
    ge0     = (num_ext >= req_i.den);
    rem_sh  = {rem_q, 1'b0};
    ge      = (rem_sh >= {1'b0, den_q});
    rem_nx  = ge ? DB'(rem_sh - {1'b0, den_q}) : rem_sh[DB-1:0];
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

  always_ff @(posedge clk_i) begin
    if (req_i.start && !busy_q) begin
      den_q <= req_i.den;
      rem_q <= ge0 ? num_ext - req_i.den : num_ext;
      quo_q <= SB'(ge0);
    end else if (busy_q) begin
      rem_q <= rem_nx;
      quo_q <= {quo_q[SB-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= KB'(lhs_pkg::FRACTION_BITS);
      end else if (busy_q) begin
        cnt_q <= cnt_q - KB'(1);
        if (cnt_q == KB'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== src/lhs_back.sv =====
// ----------------------------------------------------------------------------
// lhs_back
// Pops snapshots, forms the denominators (cube through a shared multiplier),
// runs the divider and holds the result in the output register.
// ----------------------------------------------------------------------------
module lhs_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  lhs_pkg::lhs_snap_t            snap_i,
  input  logic                          queue_empty_i,
  output logic                          pop_o,
  output lhs_pkg::lhs_div_req_t         div_req_o,
  input  lhs_pkg::lhs_div_rsp_t         div_rsp_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [lhs_pkg::SIM_BITS-1:0]  forward_similarity_o,
  output logic [lhs_pkg::SIM_BITS-1:0]  reverse_similarity_o,
  output logic                          zero_denominator_o
);

  localparam int AB = lhs_pkg::ACC_BITS;
  localparam int EB = lhs_pkg::EXC_BITS;
  localparam int QB = lhs_pkg::SQ_BITS;
  localparam int CB = lhs_pkg::CUBE_BITS;
  localparam int DB = lhs_pkg::DEN_BITS;
  localparam int SB = lhs_pkg::SIM_BITS;

  lhs_pkg::lhs_state_e state_q, state_d;
  lhs_pkg::lhs_snap_t  snap_q;

  logic          pass_q;
  logic [EB-1:0] e_q;
  logic [QB-1:0] sq_q;
  logic [CB-1:0] cube_q;
  logic [SB-1:0] fwd_q, rev_q;
  logic          zero_q;
  logic          out_valid_q;
  logic [SB-1:0] out_fwd_q, out_rev_q;
  logic          out_zero_q;

  logic [AB-1:0] e_sel, tot_min;
  logic          special, more_pass, fin, fin_zero, out_free;
  logic [SB-1:0] fin_val;
  logic [EB-1:0] mul_a;
  logic [QB-1:0] mul_p;

  assign more_pass = (snap_q.mode == lhs_pkg::MODE_CUBIC) && !pass_q;
  assign out_free  = !out_valid_q || out_ready_i;

  // forward uses the query excess, reverse the source excess
  always_comb begin
    e_sel   = pass_q ? snap_q.source_excess : snap_q.query_excess;
    tot_min = (snap_q.source_total < snap_q.query_total) ? snap_q.source_total
                                                         : snap_q.query_total;
    if (snap_q.mode == lhs_pkg::MODE_OVERLAP) begin
      special  = (tot_min == '0);
      fin_zero = special;
    end else begin
      fin_zero = (snap_q.min_sum == '0) && (e_sel == '0);
      // huge penalty: quotient is zero
      special  = fin_zero || (e_sel[AB-1:EB] != '0);
    end
  end

  // shared multiplier: e*e, then low and high halves of the square times e
  always_comb begin
    case (state_q)
      lhs_pkg::ST_SQUARE:  mul_a = e_q;
      lhs_pkg::ST_CUBE_LO: mul_a = sq_q[EB-1:0];
      default:             mul_a = sq_q[QB-1:EB];
    endcase
    mul_p = QB'(mul_a * e_q);
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      lhs_pkg::ST_IDLE: begin
        if (!queue_empty_i) state_d = lhs_pkg::ST_SETUP;
      end
      lhs_pkg::ST_SETUP: begin
        if (special) begin
          state_d = more_pass ? lhs_pkg::ST_SETUP : lhs_pkg::ST_OUTPUT;
        end else if (snap_q.mode == lhs_pkg::MODE_OVERLAP) begin
          state_d = lhs_pkg::ST_DIVIDE;
        end else begin
          state_d = lhs_pkg::ST_SQUARE;
        end
      end
      lhs_pkg::ST_SQUARE:  state_d = lhs_pkg::ST_CUBE_LO;
      lhs_pkg::ST_CUBE_LO: state_d = lhs_pkg::ST_CUBE_HI;
      lhs_pkg::ST_CUBE_HI: state_d = lhs_pkg::ST_DEN;
      lhs_pkg::ST_DEN:     state_d = lhs_pkg::ST_DIVIDE;
      lhs_pkg::ST_DIVIDE: begin
        if (div_rsp_i.done) begin
          state_d = more_pass ? lhs_pkg::ST_SETUP : lhs_pkg::ST_OUTPUT;
        end
      end
      lhs_pkg::ST_OUTPUT: begin
        if (out_free) state_d = lhs_pkg::ST_IDLE;
      end
      default: state_d = lhs_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    pop_o           = 1'b0;
    div_req_o.start = 1'b0;
    div_req_o.num   = snap_q.min_sum;
    div_req_o.den   = DB'(tot_min);
    fin             = 1'b0;
    fin_val         = '0;
    case (state_q)
      lhs_pkg::ST_IDLE: pop_o = !queue_empty_i;
      lhs_pkg::ST_SETUP: begin
        if (special) begin
          fin = 1'b1;
        end else if (snap_q.mode == lhs_pkg::MODE_OVERLAP) begin
          div_req_o.start = 1'b1;
        end
      end
      lhs_pkg::ST_DEN: begin
        div_req_o.start = 1'b1;
        div_req_o.den   = DB'(cube_q) + DB'(snap_q.min_sum);
      end
      lhs_pkg::ST_DIVIDE: begin
        fin     = div_rsp_i.done;
        fin_val = div_rsp_i.quo;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (state_q == lhs_pkg::ST_IDLE && !queue_empty_i) begin
      snap_q <= snap_i;
    end
    if (state_q == lhs_pkg::ST_SETUP) begin
      e_q <= e_sel[EB-1:0];
    end
    if (state_q == lhs_pkg::ST_SQUARE) begin
      sq_q <= mul_p;
    end
    if (state_q == lhs_pkg::ST_CUBE_LO) begin
      cube_q <= CB'(mul_p);
    end
    if (state_q == lhs_pkg::ST_CUBE_HI) begin
      cube_q <= cube_q + (CB'(mul_p) << EB);
    end
    if (fin) begin
      if (!pass_q) fwd_q <= fin_val;
      if (pass_q || (snap_q.mode == lhs_pkg::MODE_OVERLAP)) rev_q <= fin_val;
    end
    if (state_q == lhs_pkg::ST_OUTPUT && out_free) begin
      out_fwd_q  <= fwd_q;
      out_rev_q  <= rev_q;
      out_zero_q <= zero_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lhs_pkg::ST_IDLE;
      pass_q      <= 1'b0;
      zero_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == lhs_pkg::ST_IDLE && !queue_empty_i) begin
        pass_q <= 1'b0;
        zero_q <= 1'b0;
      end else if (fin) begin
        zero_q <= zero_q | fin_zero;
        if (more_pass) pass_q <= 1'b1;
      end
      if (state_q == lhs_pkg::ST_OUTPUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o          = out_valid_q;
  assign forward_similarity_o = out_fwd_q;
  assign reverse_similarity_o = out_rev_q;
  assign zero_denominator_o   = out_zero_q;

endmodule

// ===== src/label_histogram_similarity_core.sv =====
// ----------------------------------------------------------------------------
// label_histogram_similarity_core
// Overlap coefficient / cubic-penalty similarity of two label histograms.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one label per beat: tdata = {query_count, source_count},
//   tlast marks the last label of the vector pair. Non-last beats produce no
//   result; the last beat produces one m_axis beat with tdata =
//   {reverse_similarity, forward_similarity} (Q1.16, 65536 = 1.0) and
//   tuser = zero_denominator.
//   The front end takes one beat per cycle while the two-entry snapshot queue
//   has room; the accumulators saturate at 2^24 - 1.
//   The back end works one vector at a time: one 16-step divide in overlap
//   mode and, in cubic mode, two passes of a three-step shared-multiplier
//   cube plus a 16-step divide each, from snapshot to result register; a
//   pass with a zero denominator or a huge penalty skips these steps.
//   A stalled m_axis holds the result register; the queue keeps filling and
//   s_axis tready drops only when the queue is full.
//   The APB register at offset 0 selects the measure (bit 0); write it while
//   idle. Reset clears the accumulators, queue, sequencer and the register.
// ----------------------------------------------------------------------------
module label_histogram_similarity_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // [15:0] source_count, [31:16] query_count
  input  logic [lhs_pkg::IN_TDATA_BITS-1:0]   s_axis_tdata_i,
  input  logic                                s_axis_tlast_i,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // [16:0] forward_similarity, [33:17] reverse_similarity, rest zero
  output logic [lhs_pkg::OUT_TDATA_BITS-1:0]  m_axis_tdata_o,
  // [0] zero_denominator
  output logic                                m_axis_tuser_o,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  input  logic                                psel_i,
  input  logic                                penable_i,
  input  logic                                pwrite_i,
  input  logic [lhs_pkg::APB_ADDR_BITS-1:0]   paddr_i,
  input  logic [lhs_pkg::APB_DATA_BITS-1:0]   pwdata_i,
  output logic [lhs_pkg::APB_DATA_BITS-1:0]   prdata_o,
  output logic                                pready_o
);

  localparam int CB = lhs_pkg::COUNT_BITS;
  localparam int SB = lhs_pkg::SIM_BITS;

  logic                  mode_q;
  logic                  queue_full, queue_empty, push, pop;
  lhs_pkg::lhs_snap_t    push_snap, pop_snap;
  lhs_pkg::lhs_div_req_t div_req;
  lhs_pkg::lhs_div_rsp_t div_rsp;
  logic [SB-1:0]         fwd_sim, rev_sim;
  logic                  zero_den;

  assign pready_o = 1'b1;
  assign prdata_o = (paddr_i[2] == lhs_pkg::REG_MEASURE_MODE)
                    ? lhs_pkg::APB_DATA_BITS'(mode_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= lhs_pkg::MODE_OVERLAP;
    end else if (psel_i && penable_i && pwrite_i && pready_o &&
                 paddr_i[2] == lhs_pkg::REG_MEASURE_MODE) begin
      mode_q <= pwdata_i[0];
    end
  end

  lhs_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .mode_i         (mode_q),
    .in_valid_i     (s_axis_tvalid_i),
    .in_ready_o     (s_axis_tready_o),
    .source_count_i (s_axis_tdata_i[CB-1:0]),
    .query_count_i  (s_axis_tdata_i[2*CB-1:CB]),
    .last_element_i (s_axis_tlast_i),
    .queue_full_i   (queue_full),
    .push_o         (push),
    .snap_o         (push_snap)
  );

  lhs_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_snap),
    .pop_i       (pop),
    .pop_data_o  (pop_snap),
    .full_o      (queue_full),
    .empty_o     (queue_empty)
  );

  lhs_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  lhs_back u_back (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .snap_i               (pop_snap),
    .queue_empty_i        (queue_empty),
    .pop_o                (pop),
    .div_req_o            (div_req),
    .div_rsp_i            (div_rsp),
    .out_valid_o          (m_axis_tvalid_o),
    .out_ready_i          (m_axis_tready_i),
    .forward_similarity_o (fwd_sim),
    .reverse_similarity_o (rev_sim),
    .zero_denominator_o   (zero_den)
  );

  assign m_axis_tdata_o = lhs_pkg::OUT_TDATA_BITS'({rev_sim, fwd_sim});
  assign m_axis_tuser_o = zero_den;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !queue_full)
    else $error("snapshot pushed into a full queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !queue_empty)
    else $error("snapshot popped from an empty queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (fwd_sim <= lhs_pkg::ONE_Q) && (rev_sim <= lhs_pkg::ONE_Q))
    else $error("similarity above 1.0");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && zero_den) |-> (fwd_sim == '0 || rev_sim == '0))
    else $error("zero denominator flagged with both similarities nonzero");

endmodule
